/* rtl/hfl_pkg.sv */
// shared types, codes and constants for the hex-framed link receiver
package hfl_pkg;

	// receiver phase, one-hot
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_SEQ  = 6'b000010,
		PH_LEN  = 6'b000100,
		PH_FUNC = 6'b001000,
		PH_PAY  = 6'b010000,
		PH_CSUM = 6'b100000
	} phase_t;

	// frame type codes
	localparam logic [1:0] FT_CMD  = 2'd0;
	localparam logic [1:0] FT_DATA = 2'd1;
	localparam logic [1:0] FT_CAN  = 2'd2;
	localparam logic [1:0] FT_ACK  = 2'd3;

	// type bytes on the wire
	localparam logic [7:0] TB_CMD  = 8'h01;
	localparam logic [7:0] TB_DATA = 8'h02;
	localparam logic [7:0] TB_ACK  = 8'h06;
	localparam logic [7:0] TB_CAN  = 8'h18;

	// result kinds
	localparam logic [1:0] K_FUNC = 2'd0;
	localparam logic [1:0] K_PAY  = 2'd1;
	localparam logic [1:0] K_ACC  = 2'd2;
	localparam logic [1:0] K_REJ  = 2'd3;

	// error codes
	localparam logic [2:0] E_NONE   = 3'd0;
	localparam logic [2:0] E_TYPE   = 3'd1;
	localparam logic [2:0] E_HEX    = 3'd2;
	localparam logic [2:0] E_SEQ    = 3'd3;
	localparam logic [2:0] E_ACK    = 3'd4;
	localparam logic [2:0] E_LEN    = 3'd5;
	localparam logic [2:0] E_CSUM   = 3'd6;

	// header sizes and digit counts
	localparam logic [15:0] HDR_CMD    = 16'd4;
	localparam logic [15:0] HDR_DATA   = 16'd6;
	localparam logic [15:0] CAN_FUNCS  = 16'd4;
	localparam logic [2:0]  LEN_DIG_CMD  = 3'd2;
	localparam logic [2:0]  LEN_DIG_DATA = 3'd4;

	// reset values
	localparam logic [15:0] MAX_PAY_RST = 16'd1024;
	localparam logic [7:0]  RX_SEQ_RST  = 8'hff;

	// one result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [1:0]  packet_type;
		logic [2:0]  error_code;
		logic [7:0]  seq_number;
		logic [15:0] payload_length;
		logic        last;
	} res_t;

	// uppercase hex digit decode: {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

/* rtl/hfl_decode.sv */
// frame state and per-byte decode: up to two results per item
module hfl_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           func,
	input  logic [7:0]     rx_byte,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data,
	output logic [1:0]     res_cnt,
	output hfl_pkg::res_t  res0,
	output hfl_pkg::res_t  res1
);
	import hfl_pkg::*;

	phase_t      phase_q, ph_d;
	logic [1:0]  ft_q, ft_d;
	logic [3:0]  hn_q, hn_d;
	logic [1:0]  dc_q, dc_d;
	logic [15:0] bl_q, bl_d;
	logic [15:0] fl_q, fl_d;
	logic [7:0]  rs_q, rs_d;
	logic [7:0]  rx_q, rx_d;
	logic [7:0]  tx_q, tx_d;
	logic [7:0]  fs_q, fs_d;
	logic [15:0] maxp_q;

	logic        hex_ok;
	logic [3:0]  hex_n;
	logic [7:0]  seq_full;
	logic [7:0]  rx_inc;
	logic [7:0]  rs_sub;
	logic [15:0] bl_new;
	logic [15:0] bl_dec;
	logic [2:0]  dig_cnt;
	logic [2:0]  dig_need;
	logic [15:0] hdr;
	logic [15:0] pay_len;
	logic        fin;
	logic [2:0]  fin_err;
	logic        fwd;
	logic [1:0]  fwd_kind;
	res_t        r_fwd, r_fin;

	// per-byte helpers
	assign {hex_ok, hex_n} = hex_decode(rx_byte);
	assign seq_full = {hn_q, hex_n};
	assign rs_sub   = rs_q - rx_byte;
	assign bl_new   = {bl_q[11:0], hex_n};
	assign bl_dec   = bl_q - 16'd1;
	assign dig_cnt  = {1'b0, dc_q} + 3'd1;
	assign dig_need = (ft_q == FT_CMD) ? LEN_DIG_CMD : LEN_DIG_DATA;
	assign hdr      = (ft_q == FT_CMD) ? HDR_CMD : HDR_DATA;
	assign pay_len  = bl_new - hdr;

	// next state and result selection
	always_comb begin
		ph_d = phase_q; ft_d = ft_q; hn_d = hn_q; dc_d = dc_q;
		bl_d = bl_q; fl_d = fl_q; rs_d = rs_q; rx_d = rx_q;
		tx_d = tx_q; fs_d = fs_q;
		rx_inc = rx_q + 8'd1;
		fin = 1'b0; fin_err = E_NONE;
		fwd = 1'b0; fwd_kind = K_FUNC;
		if (func) begin
			tx_d = tx_q + 8'd1;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					fs_d = '0; fl_d = '0; rs_d = '0;
					dc_d = '0; hn_d = '0; bl_d = '0;
					ph_d = PH_SEQ;
					unique case (rx_byte)
						TB_CMD:  ft_d = FT_CMD;
						TB_DATA: ft_d = FT_DATA;
						TB_CAN:  ft_d = FT_CAN;
						TB_ACK:  ft_d = FT_ACK;
						default: begin
							ft_d = FT_CMD;
							fin = 1'b1; fin_err = E_TYPE;
						end
					endcase
				end
				PH_SEQ: begin
					if (!hex_ok) begin
						fin = 1'b1; fin_err = E_HEX;
					end else if (dc_q == 2'd0) begin
						hn_d = hex_n; dc_d = 2'd1;
					end else begin
						dc_d = 2'd0;
						fs_d = seq_full;
						if (ft_q == FT_ACK) begin
							fin = 1'b1;
							fin_err = (tx_q == seq_full + 8'd1) ? E_NONE : E_ACK;
						end else begin
							// cancel resyncs when the counter wraps to zero
							if (ft_q == FT_CAN && rx_inc == 8'd0) rx_inc = seq_full;
							rx_d = rx_inc;
							if (rx_inc != seq_full) begin
								fin = 1'b1; fin_err = E_SEQ;
							end else if (ft_q == FT_CAN) begin
								ph_d = PH_FUNC; bl_d = CAN_FUNCS;
							end else begin
								ph_d = PH_LEN; bl_d = '0;
							end
						end
					end
				end
				PH_LEN: begin
					if (!hex_ok) begin
						fin = 1'b1; fin_err = E_HEX;
					end else begin
						rs_d = rs_sub;
						bl_d = bl_new;
						if (dig_cnt < dig_need) begin
							dc_d = dig_cnt[1:0];
						end else begin
							dc_d = 2'd0;
							if (bl_new < hdr || pay_len > maxp_q) begin
								fin = 1'b1; fin_err = E_LEN;
							end else begin
								fl_d = pay_len; bl_d = hdr; ph_d = PH_FUNC;
							end
						end
					end
				end
				PH_FUNC: begin
					rs_d = rs_sub;
					fwd = 1'b1; fwd_kind = K_FUNC;
					bl_d = bl_dec;
					if (bl_dec == 16'd0) begin
						if (ft_q == FT_CAN) begin
							fin = 1'b1; fin_err = E_NONE;
						end else if (fl_q == 16'd0) begin
							ph_d = PH_CSUM;
						end else begin
							ph_d = PH_PAY; bl_d = fl_q;
						end
					end
				end
				PH_PAY: begin
					rs_d = rs_sub;
					fwd = 1'b1; fwd_kind = K_PAY;
					bl_d = bl_dec;
					if (bl_dec == 16'd0) ph_d = PH_CSUM;
				end
				PH_CSUM: begin
					if (!hex_ok) begin
						fin = 1'b1; fin_err = E_HEX;
					end else if (dc_q == 2'd0) begin
						hn_d = hex_n; dc_d = 2'd1;
					end else begin
						fin = 1'b1;
						fin_err = (seq_full == rs_q) ? E_NONE : E_CSUM;
					end
				end
				default: begin
					ph_d = PH_IDLE; dc_d = 2'd0;
				end
			endcase
			// any end of frame goes back to idle
			if (fin) begin
				ph_d = PH_IDLE; dc_d = 2'd0;
			end
		end
	end

	// result items carry the frame fields after this byte
	always_comb begin
		r_fwd = '{kind: fwd_kind, value: rx_byte, packet_type: ft_d,
			error_code: E_NONE, seq_number: fs_d, payload_length: fl_d, last: !fin};
		r_fin = '{kind: (fin_err == E_NONE) ? K_ACC : K_REJ, value: 8'd0,
			packet_type: ft_d, error_code: fin_err, seq_number: fs_d,
			payload_length: fl_d, last: 1'b1};
		res0 = fwd ? r_fwd : r_fin;
		res1 = r_fin;
		res_cnt = {1'b0, fwd} + {1'b0, fin};
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ft_q <= '0; hn_q <= '0; dc_q <= '0;
			bl_q <= '0; fl_q <= '0; rs_q <= '0;
			rx_q <= RX_SEQ_RST; tx_q <= '0; fs_q <= '0;
		end else if (accept) begin
			phase_q <= ph_d;
			ft_q <= ft_d; hn_q <= hn_d; dc_q <= dc_d;
			bl_q <= bl_d; fl_q <= fl_d; rs_q <= rs_d;
			rx_q <= rx_d; tx_q <= tx_d; fs_q <= fs_d;
		end
	end

	// payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxp_q <= MAX_PAY_RST;
		end else if (cfg_we) begin
			maxp_q <= cfg_data;
		end
	end

endmodule

/* rtl/hfl_outq.sv */
// three-entry result queue between decode and the output stream
module hfl_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [1:0]     push_cnt,
	input  hfl_pkg::res_t  push0,
	input  hfl_pkg::res_t  push1,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output hfl_pkg::res_t  out_res
);
	import hfl_pkg::*;

	res_t       ent_q [3];
	res_t       ent_d [3];
	logic [1:0] cnt_q, cnt_pop, cnt_d;
	logic       pop;

	// room for the largest burst of one item
	assign room      = (cnt_q <= 2'd1);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = ent_q[0];
	assign pop       = out_valid && out_ready;
	assign cnt_pop   = cnt_q - {1'b0, pop};
	assign cnt_d     = cnt_pop + (push ? push_cnt : 2'd0);

	// shift out the head, then append new results
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ent_d[i] = (pop && i < 2) ? ent_q[(i < 2) ? i + 1 : i] : ent_q[i];
			if (push && push_cnt != 2'd0 && i[1:0] == cnt_pop) ent_d[i] = push0;
			if (push && push_cnt == 2'd2 && i[1:0] == cnt_pop + 2'd1) ent_d[i] = push1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

endmodule

/* rtl/hex_framed_link_packet_receiver_unit.sv */
// top level of the hex-framed link packet receiver
// results of an accepted item are written into the result queue registers and leave from its head on m_axis
// throughput: one item per cycle while results are taken as they come
// an item may yield two results; s_axis_tready drops while two or more wait
// reset: async active low, idle phase, rx sequence 0xff, payload limit 1024
module hex_framed_link_packet_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// value[7:0], packet_type[9:8], error_code[12:10], seq_number[20:13],
	// payload_length[36:21], zero fill[39:37]
	output logic [39:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data        // max_payload
);
	import hfl_pkg::*;

	logic       accept;
	logic [1:0] res_cnt;
	res_t       res0, res1, head;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;

	// frame decode and state
	hfl_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (s_axis_tuser),
		.rx_byte  (s_axis_tdata),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.res_cnt  (res_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	// result queue
	hfl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_cnt  (res_cnt),
		.push0     (res0),
		.push1     (res1),
		.room      (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (head)
	);

	// output packing
	assign m_axis_tdata = {3'b000, head.payload_length, head.seq_number,
		head.error_code, head.packet_type, head.value};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

/* rtl/hfl_check.sv */
// port-level checks for the hex-framed link receiver, bound to the top level
module hfl_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import hfl_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// an end result always closes the run of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("end result without tlast");

	// forwarded bytes and accepted frames carry no error
	a_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != K_REJ |-> m_axis_tdata[12:10] == E_NONE)
		else $error("error code on a non-rejected result");

	// a rejection always names its cause
	a_rej_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == K_REJ |-> m_axis_tdata[12:10] != E_NONE)
		else $error("rejection without error code");

	// a send event on an empty output yields nothing
	a_tx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("send event produced a result");

endmodule

bind hex_framed_link_packet_receiver_unit hfl_check u_check (.*);
